// ===== rtl/core/mat_pkg.sv =====
// ----------------------------------------------------------------------------
// mat_pkg
// Shared widths, register map and control types of the moving average
// threshold alert block.
// ----------------------------------------------------------------------------
package mat_pkg;

   localparam int DATA_W = 16;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 2;

   localparam logic [CSR_ADDR_W-1:0] ADDR_ALERT_THRESHOLD = 2'd0;
   localparam logic signed [DATA_W-1:0] THRESHOLD_RESET = 16'sd6784;

   // Control from the sequencer to the divider.
   typedef struct packed {
      logic start;
   } div_ctrl_type;

   // Status from the divider back to the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ===== rtl/core/mat_if.sv =====
// ----------------------------------------------------------------------------
// mat_req_if / mat_rsp_if
// Valid/ready channels carrying samples in and averages with alert flags out.
// ----------------------------------------------------------------------------
interface mat_req_if
   import mat_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface mat_rsp_if
   import mat_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] average;
   logic                     alert_active;
   logic                     alert_raised;
   logic                     alert_cleared;

   modport source (output valid, output average, output alert_active,
                   output alert_raised, output alert_cleared, input ready);
   modport sink   (input valid, input average, input alert_active,
                   input alert_raised, input alert_cleared, output ready);
endinterface

// ===== rtl/core/mat_ram.sv =====
// ----------------------------------------------------------------------------
// mat_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mat_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 10
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/mat_divider.sv =====
// ----------------------------------------------------------------------------
// mat_divider
// Restoring unsigned divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mat_divider
   import mat_pkg::*;
#(
   parameter int DIVIDEND_W = 20,
   parameter int DIVISOR_W  = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  div_ctrl_type          ctrl,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output div_stat_type          stat,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int STEP_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] quot_ff, quot_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  div_ff, div_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   logic [DIVISOR_W:0] rem_shift;
   logic [DIVISOR_W:0] rem_diff;
   logic               fits;

   always_comb begin
      rem_shift = {rem_ff, quot_ff[DIVIDEND_W-1]};
      rem_diff  = rem_shift - {1'b0, div_ff};
      fits      = rem_shift >= {1'b0, div_ff};

      quot_in = quot_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (ctrl.start) begin
         quot_in = dividend;
         rem_in  = '0;
         div_in  = divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // The remainder stays below the divisor, so it fits the divisor width.
         rem_in  = fits ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
         quot_in = {quot_ff[DIVIDEND_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quot_ff;

endmodule

// ===== rtl/core/moving_average_threshold_alert.sv =====
// ----------------------------------------------------------------------------
// moving_average_threshold_alert
// Each accepted sample (signed Q8.8) is written into a ring of the last WINDOW
// samples and the running sum is updated; the block then returns the mean over
// the samples seen so far (over WINDOW once the ring has wrapped), truncated
// toward zero, with a latched alert that is set while the mean is strictly
// above alert_threshold and one-transfer pulses when it sets or clears. One
// item is worked on at a time; it passes through a ring read, a sum update, a
// divider start, the restoring divider, which produces one quotient bit per
// cycle over the SUM_W = 16 + clog2(WINDOW) bits of the sum, a state in which
// the divider's done flag is seen and a result state. A finished result waits
// in the output register while the next sample is taken. The threshold
// register sits at byte address 0.
// ----------------------------------------------------------------------------
module moving_average_threshold_alert
   import mat_pkg::*;
#(
   parameter int WINDOW = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   mat_req_if.sink               req_bus,
   mat_rsp_if.source             rsp_bus,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int SUM_W  = DATA_W + $clog2(WINDOW);
   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SUM,
      ST_START,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   logic signed [DATA_W-1:0] threshold_ff, threshold_in;
   logic signed [DATA_W-1:0] sample_ff, sample_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [SLOT_W-1:0]        slot_ff, slot_in;
   logic                     full_ff, full_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     latched_ff, latched_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_average_ff, rsp_average_in;
   logic                     rsp_active_ff, rsp_active_in;
   logic                     rsp_raised_ff, rsp_raised_in;
   logic                     rsp_cleared_ff, rsp_cleared_in;

   logic                     ram_wr_en;
   logic [DATA_W-1:0]        ram_rd_data;
   logic signed [DATA_W-1:0] old_sample;
   logic signed [SUM_W-1:0]  old_ext;
   logic signed [SUM_W-1:0]  new_ext;
   logic                     sum_neg;
   logic [SUM_W-1:0]         sum_mag;
   logic [SUM_W-1:0]         quotient;
   logic [SUM_W-1:0]         mean_wide;
   logic signed [DATA_W-1:0] mean;
   logic                     above;
   logic                     csr_write;

   div_ctrl_type div_ctrl;
   div_stat_type div_stat;

   mat_ram #(
      .WIDTH (DATA_W),
      .DEPTH (WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_ff),
      .wr_data (sample_ff),
      .rd_addr (slot_ff),
      .rd_data (ram_rd_data)
   );

   mat_divider #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR_W  (CNT_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (sum_mag),
      .divisor  (count_ff),
      .stat     (div_stat),
      .quotient (quotient)
   );

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr == ADDR_ALERT_THRESHOLD) ?
                       CSR_DATA_W'(threshold_ff) : '0;

   always_comb begin
      // Before the first wrap the slot being overwritten has never been written.
      old_sample = full_ff ? signed'(ram_rd_data) : '0;
      old_ext    = SUM_W'(old_sample);
      new_ext    = SUM_W'(sample_ff);
      sum_neg    = sum_ff[SUM_W-1];
      sum_mag    = sum_neg ? (-sum_ff) : sum_ff;
      mean_wide  = sum_neg ? (-quotient) : quotient;
      mean       = signed'(mean_wide[DATA_W-1:0]);
      above      = mean > threshold_ff;
      ram_wr_en  = (state_ff == ST_SUM);
      div_ctrl.start = (state_ff == ST_START);
   end

   always_comb begin
      state_in       = state_ff;
      threshold_in   = threshold_ff;
      sample_in      = sample_ff;
      sum_in         = sum_ff;
      slot_in        = slot_ff;
      full_in        = full_ff;
      count_in       = count_ff;
      latched_in     = latched_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_average_in = rsp_average_ff;
      rsp_active_in  = rsp_active_ff;
      rsp_raised_in  = rsp_raised_ff;
      rsp_cleared_in = rsp_cleared_ff;

      if (csr_write && (csr_paddr == ADDR_ALERT_THRESHOLD)) begin
         threshold_in = signed'(csr_pwdata[DATA_W-1:0]);
      end

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               sample_in = req_bus.sample;
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            sum_in = sum_ff - old_ext + new_ext;
            if (slot_ff == SLOT_W'(WINDOW - 1)) begin
               slot_in  = '0;
               full_in  = 1'b1;
               count_in = CNT_W'(WINDOW);
            end else begin
               slot_in  = slot_ff + 1'b1;
               count_in = full_ff ? CNT_W'(WINDOW) : CNT_W'(slot_ff) + 1'b1;
            end
            state_in = ST_START;
         end
         ST_START: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Hold the result until the output register has been emptied.
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_average_in = mean;
               rsp_raised_in  = above && !latched_ff;
               rsp_cleared_in = !above && latched_ff;
               rsp_active_in  = above;
               latched_in     = above;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         threshold_ff <= THRESHOLD_RESET;
         sum_ff       <= '0;
         slot_ff      <= '0;
         full_ff      <= 1'b0;
         count_ff     <= '0;
         latched_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         threshold_ff <= threshold_in;
         sum_ff       <= sum_in;
         slot_ff      <= slot_in;
         full_ff      <= full_in;
         count_ff     <= count_in;
         latched_ff   <= latched_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff      <= sample_in;
      rsp_average_ff <= rsp_average_in;
      rsp_active_ff  <= rsp_active_in;
      rsp_raised_ff  <= rsp_raised_in;
      rsp_cleared_ff <= rsp_cleared_in;
   end

   assign req_bus.ready         = (state_ff == ST_IDLE);
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.average       = rsp_average_ff;
   assign rsp_bus.alert_active  = rsp_active_ff;
   assign rsp_bus.alert_raised  = rsp_raised_ff;
   assign rsp_bus.alert_cleared = rsp_cleared_ff;

endmodule

// ===== bench/moving_average_threshold_alert_checker.sv =====
// ----------------------------------------------------------------------------
// moving_average_threshold_alert_checker
// Watches the sample, result and register ports of the moving average block.
// It keeps its own copy of the sample window, running sum, alert latch and
// threshold, predicts one result for every accepted sample and compares each
// result transfer field by field with the oldest prediction. Register reads
// are compared with the threshold held here.
// ----------------------------------------------------------------------------
module moving_average_threshold_alert_checker
   import mat_pkg::*;
#(
   parameter int WINDOW = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   mat_req_if                    req_mon,
   mat_rsp_if                    rsp_mon,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic [CSR_DATA_W-1:0] csr_prdata,
   input  logic                  csr_pready,
   output int                    fail_count,
   output int                    pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SUM_W = DATA_W + $clog2(WINDOW);

   typedef struct packed {
      logic signed [DATA_W-1:0] average;
      logic                     active;
      logic                     raised;
      logic                     cleared;
   } alert_result_type;

   logic signed [DATA_W-1:0] window_ring [WINDOW];
   int                       fill_slot;
   logic                     window_full;
   logic signed [SUM_W-1:0]  window_sum;
   logic                     alert_latched;
   logic signed [DATA_W-1:0] alert_threshold;

   alert_result_type         expected_results [$];
   alert_result_type         oldest;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   // Stores one sample and works out the mean and alert flags that follow it.
   function automatic alert_result_type take_sample(input logic signed [DATA_W-1:0] value);
      alert_result_type r;
      int               divisor;
      int               mean;
      window_sum = window_sum - window_ring[fill_slot] + value;
      window_ring[fill_slot] = value;
      fill_slot = (fill_slot == WINDOW - 1) ? 0 : fill_slot + 1;
      if (fill_slot == 0) begin
         window_full = 1'b1;
      end
      divisor = window_full ? WINDOW : fill_slot;
      // Integer division truncates toward zero, as the block does.
      mean = int'(window_sum) / divisor;
      r.raised = 1'b0;
      r.cleared = 1'b0;
      if (mean > alert_threshold && !alert_latched) begin
         alert_latched = 1'b1;
         r.raised = 1'b1;
      end else if (mean <= alert_threshold && alert_latched) begin
         alert_latched = 1'b0;
         r.cleared = 1'b1;
      end
      r.average = mean[DATA_W-1:0];
      r.active = alert_latched;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW; i++) begin
            window_ring[i] = '0;
         end
         fill_slot = 0;
         window_full = 1'b0;
         window_sum = '0;
         alert_latched = 1'b0;
         alert_threshold = THRESHOLD_RESET;
         expected_results.delete();
         fail_count = 0;
         pending_count = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result transfer with no sample outstanding",
                               rsp_mon.average, 0);
            end else begin
               oldest = expected_results.pop_front();
               if (rsp_mon.average !== oldest.average) begin
                  report_mismatch("average", rsp_mon.average, oldest.average);
               end
               if (rsp_mon.alert_active !== oldest.active) begin
                  report_mismatch("alert_active", rsp_mon.alert_active, oldest.active);
               end
               if (rsp_mon.alert_raised !== oldest.raised) begin
                  report_mismatch("alert_raised", rsp_mon.alert_raised, oldest.raised);
               end
               if (rsp_mon.alert_cleared !== oldest.cleared) begin
                  report_mismatch("alert_cleared", rsp_mon.alert_cleared, oldest.cleared);
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_results.push_back(take_sample(req_mon.sample));
         end
         if (csr_psel && csr_penable && csr_pready && csr_paddr == ADDR_ALERT_THRESHOLD) begin
            if (csr_pwrite) begin
               alert_threshold = csr_pwdata[DATA_W-1:0];
            end else if (csr_prdata[DATA_W-1:0] !== alert_threshold) begin
               report_mismatch("alert_threshold read",
                               $signed(csr_prdata[DATA_W-1:0]), alert_threshold);
            end
         end
         pending_count = expected_results.size();
      end
   end

endmodule

// ===== bench/moving_average_threshold_alert_tb.sv =====
// ----------------------------------------------------------------------------
// moving_average_threshold_alert_tb
// Drives samples into the moving average block under several alert thresholds,
// with random gaps on the sample side and random stalls on the result side.
// A directed run covers the extremes and the threshold boundary, then random
// samples cluster round each threshold so that the alert sets and clears often.
// The checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module moving_average_threshold_alert_tb
   import mat_pkg::*;
   ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WINDOW = 10;
   localparam int PHASES = 8;
   localparam int SAMPLES_PER_PHASE = 243;
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 40;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    fail_count;
   int                    pending_count;
   int                    cycle_count;
   logic                  no_idle;

   logic signed [DATA_W-1:0] directed_samples [0:23] = '{
      16'sd6784, 16'sd6800, 16'sd6768, -16'sd1, 16'sd0, 16'sd1,
      -16'sd32768, 16'sd32767, 16'sd32767, 16'sd32767,
      16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
      16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
      -16'sd32768, -16'sd32768, -16'sd1, 16'sd1, -16'sd2, 16'sd3
   };

   mat_req_if req_bus ();
   mat_rsp_if rsp_bus ();

   moving_average_threshold_alert #(
      .WINDOW (WINDOW)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   moving_average_threshold_alert_checker #(
      .WINDOW (WINDOW)
   ) alert_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   // Result side: a random stall before each transfer, none in phases with no_idle set.
   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         @(negedge clock);
         stall = no_idle ? 0 : $urandom_range(0, 13);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
      end
   end

   task automatic send_sample(input logic signed [DATA_W-1:0] value);
      int gap;
      @(negedge clock);
      gap = no_idle ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.sample <= value;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
   endtask

   // The threshold is changed only once every outstanding result has arrived;
   // it is then read back.
   task automatic program_threshold(input logic signed [DATA_W-1:0] value);
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= ADDR_ALERT_THRESHOLD;
      csr_pwdata <= {16'($urandom), value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   initial begin
      logic signed [DATA_W-1:0] threshold;
      int                       value;
      reset <= 1'b1;
      no_idle <= 1'b0;
      req_bus.valid <= 1'b0;
      req_bus.sample <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Read back the reset threshold, then walk the boundary and the extremes.
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_paddr <= ADDR_ALERT_THRESHOLD;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      threshold = THRESHOLD_RESET;
      foreach (directed_samples[i]) begin
         send_sample(directed_samples[i]);
      end

      for (int phase = 1; phase <= PHASES; phase++) begin
         case (phase)
            1: threshold = -16'sd32768;
            2: threshold = 16'sd32767;
            3: threshold = 16'sd0;
            default: threshold = 16'($urandom);
         endcase
         program_threshold(threshold);
         no_idle <= ($urandom_range(0, 3) == 0);
         for (int n = 0; n < SAMPLES_PER_PHASE; n++) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: begin
                  // Close to the threshold, so the mean keeps crossing it.
                  value = int'(threshold) + $urandom_range(0, 512) - 256;
                  if (value > 32767) begin
                     value = 32767;
                  end else if (value < -32768) begin
                     value = -32768;
                  end
               end
               6: value = $urandom_range(0, 1) ? 32767 : -32768;
               7: value = $urandom_range(0, 8) - 4;
               default: value = $signed(16'($urandom));
            endcase
            send_sample(value[DATA_W-1:0]);
         end
      end

      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
